// ===== rtl/core/gated_nearest_point_select_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gated nearest point select
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GATED_NEAREST_POINT_SELECT_ASSERT_SVH
`define GATED_NEAREST_POINT_SELECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GNPS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GNPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gnps_pkg.sv =====
// ----------------------------------------------------------------------------
// Gated nearest point select package
// Widths, register indices and the types shared between the front end,
// the work queue and the selection back end.
// ----------------------------------------------------------------------------
package gnps_pkg;

  localparam int unsigned ACC_W       = 48;
  localparam int unsigned TOL_W       = 19;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned SQ_IN_W     = 24;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_TOLERANCE = 8'd0,
    REG_USE_SCALE     = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic use_tolerance;
    logic use_scale;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] term;
    logic             excluded;
    logic             end_point;
    logic             end_set;
  } work_t;

endpackage

// ===== rtl/core/gnps_front.sv =====
// ----------------------------------------------------------------------------
// Gated nearest point select front end
// Three-stage pipeline that turns one coordinate into a gate flag and a
// saturated squared term, with credit-based flow control towards the queue.
// ----------------------------------------------------------------------------
module gnps_front import gnps_pkg::*; #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         push_i,
  input  logic signed [COORD_BITS-1:0] coord_i,
  input  logic signed [COORD_BITS-1:0] query_i,
  input  logic        [TOL_W-1:0]      tolerance_i,
  input  logic        [SCALE_W-1:0]    scale_i,
  input  logic                         last_dim_i,
  input  logic                         last_point_i,
  input  logic        [QLVL_W-1:0]     queue_level_i,
  output logic                         full_o,
  output logic                         work_valid_o,
  output work_t                        work_o
);

  localparam int unsigned MW     = COORD_BITS + 1;
  localparam int unsigned CMP_W  = (MW > TOL_W) ? MW : TOL_W;
  localparam int unsigned PROD_W = MW + SCALE_W;
  localparam int unsigned RND_W  = PROD_W + 1;
  localparam int unsigned SW     = RND_W - 8;
  localparam int unsigned SXW    = (SW > SQ_IN_W) ? SW : SQ_IN_W + 1;

  logic                accept;
  logic [MW-1:0]       diff;
  logic [MW-1:0]       mag;
  logic                over_tol;
  logic [QLVL_W:0]     level_sum;

  logic                v1_q, v2_q, v3_q;
  logic [MW-1:0]       m1_q;
  logic                excl1_q, excl2_q;
  logic [SCALE_W-1:0]  scl1_q;
  logic                usc1_q;
  logic                endp1_q, endp2_q;
  logic                ends1_q, ends2_q;

  logic [PROD_W-1:0]   prod;
  logic [RND_W-1:0]    rnd;
  logic [SW-1:0]       scaled;
  logic [SW-1:0]       root_sel;
  logic [SXW-1:0]      root_ext;
  logic                sat2_d, sat2_q;
  logic [SQ_IN_W-1:0]  root2_d, root2_q;

  logic [ACC_W-1:0]    square;
  work_t               work_d, work_q;

  assign level_sum = (QLVL_W + 1)'(queue_level_i) + (QLVL_W + 1)'(v1_q)
                   + (QLVL_W + 1)'(v2_q) + (QLVL_W + 1)'(v3_q);
  assign full_o    = level_sum >= (QLVL_W + 1)'(QUEUE_DEPTH);
  assign accept    = push_i && !full_o;

  assign diff     = {coord_i[COORD_BITS-1], coord_i} - {query_i[COORD_BITS-1], query_i};
  assign mag      = diff[MW-1] ? (~diff + MW'(1)) : diff;
  assign over_tol = CMP_W'(mag) > CMP_W'(tolerance_i);

  assign prod     = PROD_W'(m1_q) * PROD_W'(scl1_q);
  assign rnd      = RND_W'(prod) + RND_W'(128);
  assign scaled   = rnd[RND_W-1:8];
  assign root_sel = usc1_q ? scaled : SW'(m1_q);
  assign root_ext = SXW'(root_sel);
  assign sat2_d   = |root_ext[SXW-1:SQ_IN_W];
  assign root2_d  = root_ext[SQ_IN_W-1:0];

  assign square = ACC_W'(root2_q) * ACC_W'(root2_q);

  always_comb begin
    work_d.term      = sat2_q ? ACC_MAX : square;
    work_d.excluded  = excl2_q;
    work_d.end_point = endp2_q;
    work_d.end_set   = ends2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q    <= mag;
    excl1_q <= cfg_i.use_tolerance && over_tol;
    scl1_q  <= scale_i;
    usc1_q  <= cfg_i.use_scale;
    endp1_q <= last_dim_i || last_point_i;
    ends1_q <= last_point_i;
    sat2_q  <= sat2_d;
    root2_q <= root2_d;
    excl2_q <= excl1_q;
    endp2_q <= endp1_q;
    ends2_q <= ends1_q;
    work_q  <= work_d;
  end

  assign work_valid_o = v3_q;
  assign work_o       = work_q;

endmodule

// ===== rtl/core/gnps_fifo.sv =====
// ----------------------------------------------------------------------------
// Gated nearest point select work queue
// Small first-in first-out buffer of squared terms between the front end
// and the selection back end.
// ----------------------------------------------------------------------------
module gnps_fifo import gnps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  work_t             wdata_i,
  input  logic              pop_i,
  output logic              valid_o,
  output work_t             rdata_o,
  output logic [QLVL_W-1:0] level_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  work_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [QLVL_W-1:0] level_q, level_d;
  logic              do_pop;

  assign do_pop = pop_i && (level_q != '0);

  always_comb begin
    wptr_d  = push_i ? wptr_q + PTR_W'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + PTR_W'(1) : rptr_q;
    level_d = level_q + QLVL_W'(push_i) - QLVL_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign valid_o = level_q != '0;
  assign rdata_o = mem_q[rptr_q];
  assign level_o = level_q;

endmodule

// ===== rtl/core/gnps_back.sv =====
// ----------------------------------------------------------------------------
// Gated nearest point select back end
// Accumulates the terms of each point, keeps the first smallest accepted
// distance and holds the result of each set in an output register.
// ----------------------------------------------------------------------------
`include "gated_nearest_point_select_assert.svh"

module gnps_back import gnps_pkg::*; #(
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               work_valid_i,
  input  work_t              work_i,
  output logic               take_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [INDEX_W-1:0] best_index_o,
  output logic               found_o,
  output logic               index_overflow_o,
  output logic               last_o
);

  localparam int unsigned POINT_LIMIT = (MAX_POINTS < 65536) ? MAX_POINTS : 65536;
  localparam int unsigned CNT_W       = $clog2(POINT_LIMIT + 1);

  logic               take;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   acc_new;
  logic               excl_new;
  logic [INDEX_W:0]   cnt_wide;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               excl_q, excl_d;
  logic [ACC_W-1:0]   best_sum_q, best_sum_d;
  logic [INDEX_W-1:0] best_pt_q, best_pt_d;
  logic               have_q, have_d;
  logic               ovf_q, ovf_d;

  logic               out_valid_q, out_valid_d;
  logic [INDEX_W-1:0] out_index_q, out_index_d;
  logic               out_found_q, out_found_d;
  logic               out_ovf_q, out_ovf_d;

  assign take     = work_valid_i && (!work_i.end_set || !out_valid_q || pop_i);
  assign acc_sum  = {1'b0, acc_q} + {1'b0, work_i.term};
  assign acc_new  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
  assign excl_new = excl_q || work_i.excluded;
  assign cnt_wide = (INDEX_W + 1)'(cnt_q);

  always_comb begin
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    excl_d      = excl_q;
    best_sum_d  = best_sum_q;
    best_pt_d   = best_pt_q;
    have_d      = have_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !pop_i;
    out_index_d = out_index_q;
    out_found_d = out_found_q;
    out_ovf_d   = out_ovf_q;
    if (take) begin
      acc_d  = acc_new;
      excl_d = excl_new;
      if (work_i.end_point) begin
        acc_d  = '0;
        excl_d = 1'b0;
        if (cnt_q >= CNT_W'(POINT_LIMIT)) begin
          ovf_d = 1'b1;
        end else begin
          if (!excl_new && (!have_q || acc_new < best_sum_q)) begin
            best_sum_d = acc_new;
            best_pt_d  = cnt_wide[INDEX_W-1:0];
            have_d     = 1'b1;
          end
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      if (work_i.end_set) begin
        out_valid_d = 1'b1;
        out_index_d = have_d ? best_pt_d : '0;
        out_found_d = have_d;
        out_ovf_d   = ovf_d;
        cnt_d       = '0;
        best_sum_d  = '0;
        best_pt_d   = '0;
        have_d      = 1'b0;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      acc_q       <= '0;
      excl_q      <= 1'b0;
      best_sum_q  <= '0;
      best_pt_q   <= '0;
      have_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      excl_q      <= excl_d;
      best_sum_q  <= best_sum_d;
      best_pt_q   <= best_pt_d;
      have_q      <= have_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_index_q <= out_index_d;
    out_found_q <= out_found_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign take_o           = take;
  assign empty_o          = !out_valid_q;
  assign best_index_o     = out_index_q;
  assign found_o          = out_found_q;
  assign index_overflow_o = out_ovf_q;
  assign last_o           = 1'b1;

  `GNPS_ASSERT_IMPL(a_cnt_bounded, 1'b1, cnt_q <= CNT_W'(POINT_LIMIT), "point count past limit")
  `GNPS_ASSERT_IMPL(a_no_best_zero, !have_q, best_pt_q == '0, "stale best point without a best")
  `GNPS_ASSERT_IMPL(a_not_found_zero, out_valid_q && !out_found_q, out_index_q == '0,
    "result index non-zero without a found point")
  `GNPS_ASSERT_NEXT(a_set_cleared, take && work_i.end_set,
    out_valid_q && !have_q && !ovf_q && cnt_q == '0 && acc_q == '0, "set state not cleared")

endmodule

// ===== rtl/core/gated_nearest_point_select.sv =====
// ----------------------------------------------------------------------------
// Gated nearest point select
// Streaming arg-min search over candidate points, one coordinate per word,
// with an optional tolerance box gate and per-dimension scaling.
// ----------------------------------------------------------------------------
// The block takes one coordinate word per clock cycle, sustained, as long as
// results are collected; that rate is set by the accumulate-and-compare loop
// in the back end, which retires one word per cycle. A word passes three
// front-end pipeline stages (difference and gate, scale multiply, square)
// and the work queue before the back end takes it. Full rises once the queue
// and the front-end stages together hold eight words. The result of a set
// waits in an output register while the next set streams in.
module gated_nearest_point_select import gnps_pkg::*; #(
  parameter int unsigned MAX_POINTS = 65536,
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] coord_i,
  input  logic signed [COORD_BITS-1:0] query_i,
  input  logic        [TOL_W-1:0]      tolerance_i,
  input  logic        [SCALE_W-1:0]    scale_i,
  input  logic                         last_dim_i,
  input  logic                         last_point_i,
  output logic                         empty,
  input  logic                         pop,
  output logic        [INDEX_W-1:0]    best_index_o,
  output logic                         found_o,
  output logic                         index_overflow_o,
  output logic                         last_o
);

  cfg_t              cfg_q, cfg_d;
  logic              work_valid;
  work_t             work;
  logic              queue_valid;
  work_t             queue_data;
  logic [QLVL_W-1:0] queue_level;
  logic              take;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_USE_TOLERANCE: cfg_d.use_tolerance = cfg_data_i[0];
        REG_USE_SCALE:     cfg_d.use_scale     = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gnps_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .coord_i       (coord_i),
    .query_i       (query_i),
    .tolerance_i   (tolerance_i),
    .scale_i       (scale_i),
    .last_dim_i    (last_dim_i),
    .last_point_i  (last_point_i),
    .queue_level_i (queue_level),
    .full_o        (full),
    .work_valid_o  (work_valid),
    .work_o        (work)
  );

  gnps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (work_valid),
    .wdata_i (work),
    .pop_i   (take),
    .valid_o (queue_valid),
    .rdata_o (queue_data),
    .level_o (queue_level)
  );

  gnps_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .work_valid_i     (queue_valid),
    .work_i           (queue_data),
    .take_o           (take),
    .pop_i            (pop),
    .empty_o          (empty),
    .best_index_o     (best_index_o),
    .found_o          (found_o),
    .index_overflow_o (index_overflow_o),
    .last_o           (last_o)
  );

endmodule

// ===== tb/gated_nearest_point_select_checker.sv =====
// ----------------------------------------------------------------------------
// Gated nearest point select checker
// Watches the register, input and result channels of the block and keeps its
// own model of the arg-min search. Each accepted input word updates the model,
// each set-ending word queues one expected result, and each popped result is
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module gated_nearest_point_select_checker import gnps_pkg::*; #(
  parameter int unsigned MAX_POINTS = 65536,
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic signed [COORD_BITS-1:0] coord_i,
  input  logic signed [COORD_BITS-1:0] query_i,
  input  logic        [TOL_W-1:0]      tolerance_i,
  input  logic        [SCALE_W-1:0]    scale_i,
  input  logic                         last_dim_i,
  input  logic                         last_point_i,
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  logic        [INDEX_W-1:0]    best_index_i,
  input  logic                         found_i,
  input  logic                         index_overflow_i,
  input  logic                         last_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned POINT_LIMIT = (MAX_POINTS < 65536) ? MAX_POINTS : 65536;
  localparam longint unsigned SQ_LIMIT    = 64'd1 << SQ_IN_W;
  localparam longint unsigned SUM_MAX     = {16'd0, ACC_MAX};

  typedef struct packed {
    logic [INDEX_W-1:0] best_index;
    logic               found;
    logic               index_overflow;
    logic               last;
  } select_result_t;

  bit              tol_gate_on;
  bit              scale_on;
  longint unsigned point_idx;
  longint unsigned dist_sum;
  bit              excluded;
  longint unsigned best_sum;
  longint unsigned best_pt;
  bit              have_best;
  bit              overflowed;
  select_result_t  expected_q[$];

  function automatic longint unsigned square_sat(input longint unsigned v);
    return (v >= SQ_LIMIT) ? SUM_MAX : v * v;
  endfunction

  function automatic void clear_set();
    point_idx  = 0;
    dist_sum   = 0;
    excluded   = 1'b0;
    best_sum   = 0;
    best_pt    = 0;
    have_best  = 1'b0;
    overflowed = 1'b0;
  endfunction

  function automatic void absorb_word(
    input logic signed [COORD_BITS-1:0] c,
    input logic signed [COORD_BITS-1:0] q,
    input logic        [TOL_W-1:0]      tol,
    input logic        [SCALE_W-1:0]    scl,
    input logic                         end_dim,
    input logic                         end_set
  );
    logic signed [COORD_BITS:0] diff;
    longint unsigned            mag;
    longint unsigned            term;
    select_result_t             res;
    diff = c - q;
    mag  = (diff < 0) ? -diff : diff;
    if (tol_gate_on && mag > tol) begin
      excluded = 1'b1;
    end
    term = scale_on ? square_sat((mag * scl + 128) >> 8) : square_sat(mag);
    dist_sum += term;
    if (dist_sum > SUM_MAX) begin
      dist_sum = SUM_MAX;
    end
    if (end_dim || end_set) begin
      if (point_idx >= POINT_LIMIT) begin
        overflowed = 1'b1;
      end else begin
        if (!excluded && (!have_best || dist_sum < best_sum)) begin
          best_sum  = dist_sum;
          best_pt   = point_idx;
          have_best = 1'b1;
        end
        point_idx++;
      end
      dist_sum = 0;
      excluded = 1'b0;
    end
    if (end_set) begin
      res.best_index     = have_best ? INDEX_W'(best_pt) : '0;
      res.found          = have_best;
      res.index_overflow = overflowed;
      res.last           = 1'b1;
      expected_q.push_back(res);
      clear_set();
    end
  endfunction

  function automatic void check_field(
    input string              name,
    input logic [INDEX_W-1:0] want,
    input logic [INDEX_W-1:0] got
  );
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    select_result_t want;
    if (!rst_ni) begin
      tol_gate_on = 1'b0;
      scale_on    = 1'b0;
      clear_set();
      expected_q.delete();
    end else begin
      if (push_i && !full_i) begin
        absorb_word(coord_i, query_i, tolerance_i, scale_i, last_dim_i, last_point_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_USE_TOLERANCE: tol_gate_on = cfg_data_i[0];
          REG_USE_SCALE:     scale_on    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (pop_i && !empty_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual best_index %0d found %0b",
                   $time, best_index_i, found_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("best_index", want.best_index, best_index_i);
          check_field("found", want.found, found_i);
          check_field("index_overflow", want.index_overflow, index_overflow_i);
          check_field("last", want.last, last_i);
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== tb/tb_gated_nearest_point_select.sv =====
// ----------------------------------------------------------------------------
// Gated nearest point select testbench
// Drives directed sets that hit the field extremes, the tolerance gate,
// scaling, saturation and ties, then random sets under several register
// settings and pacing patterns, including a long result hold-off that fills
// the block. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module tb_gated_nearest_point_select import gnps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS    = 20;
  localparam int unsigned MAX_POINTS    = 65536;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_WORDS   = 220;
  localparam int unsigned HOLD_WORDS    = 120;
  localparam int unsigned HOLD_CYCLES   = 400;

  localparam logic [CFG_IDX_W-1:0]  UNUSED_REG = 8'hA5;
  localparam logic [COORD_BITS-1:0] MAX_COORD  = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MIN_COORD  = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [TOL_W-1:0]      MAX_TOL    = '1;
  localparam logic [SCALE_W-1:0]    MAX_SCALE  = '1;

  typedef struct packed {
    logic [COORD_BITS-1:0] coord;
    logic [COORD_BITS-1:0] query;
    logic [TOL_W-1:0]      tol;
    logic [SCALE_W-1:0]    scl;
    logic                  end_dim;
    logic                  end_set;
  } coord_word_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  push         = 1'b0;
  logic                  full;
  logic [COORD_BITS-1:0] coord_i      = '0;
  logic [COORD_BITS-1:0] query_i      = '0;
  logic [TOL_W-1:0]      tolerance_i  = '0;
  logic [SCALE_W-1:0]    scale_i      = '0;
  logic                  last_dim_i   = 1'b0;
  logic                  last_point_i = 1'b0;
  logic                  empty;
  logic                  pop          = 1'b0;
  logic [INDEX_W-1:0]    best_index_o;
  logic                  found_o;
  logic                  index_overflow_o;
  logic                  last_o;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned words_sent   = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_left    = 0;

  gated_nearest_point_select #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push, .full, .coord_i, .query_i, .tolerance_i, .scale_i, .last_dim_i,
    .last_point_i, .empty, .pop, .best_index_o, .found_o, .index_overflow_o, .last_o
  );

  gated_nearest_point_select_checker #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) result_check (
    .clk_i, .rst_ni, .cfg_valid_i,
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i, .cfg_data_i,
    .push_i           (push),
    .full_i           (full),
    .coord_i, .query_i, .tolerance_i, .scale_i, .last_dim_i, .last_point_i,
    .empty_i          (empty),
    .pop_i            (pop),
    .best_index_i     (best_index_o),
    .found_i          (found_o),
    .index_overflow_i (index_overflow_o),
    .last_i           (last_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending_results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    pop <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  function automatic coord_word_t make_word(
    input logic [COORD_BITS-1:0] c,
    input logic [COORD_BITS-1:0] q,
    input logic [TOL_W-1:0]      tol,
    input logic [SCALE_W-1:0]    scl,
    input logic                  end_dim,
    input logic                  end_set
  );
    return '{coord: c, query: q, tol: tol, scl: scl, end_dim: end_dim, end_set: end_set};
  endfunction

  task automatic send_word(input coord_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    coord_i      <= w.coord;
    query_i      <= w.query;
    tolerance_i  <= w.tol;
    scale_i      <= w.scl;
    last_dim_i   <= w.end_dim;
    last_point_i <= w.end_set;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic value);
    logic [CFG_DATA_W-1:0] noise;
    noise = $urandom();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= {noise[CFG_DATA_W-1:1], value};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic configure(input logic tol_on, input logic scale_on);
    put_reg(REG_USE_TOLERANCE, tol_on);
    put_reg(UNUSED_REG, ~scale_on);
    put_reg(REG_USE_SCALE, scale_on);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_set();
    logic [COORD_BITS-1:0] q_dim   [4];
    logic [TOL_W-1:0]      tol_dim [4];
    logic [SCALE_W-1:0]    scl_dim [4];
    logic [COORD_BITS-1:0] c;
    logic                  end_dim;
    logic                  end_set;
    int                    n_points;
    int                    n_dims;
    int                    delta;
    int                    pick;
    n_points = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    n_dims   = $urandom_range(1, 4);
    for (int d = 0; d < n_dims; d++) begin
      q_dim[d]   = COORD_BITS'($urandom());
      tol_dim[d] = TOL_W'($urandom_range(0, (1 << $urandom_range(0, TOL_W)) - 1));
      pick       = $urandom_range(2);
      if (pick == 0) begin
        scl_dim[d] = 16'd256;
      end else if (pick == 1) begin
        scl_dim[d] = SCALE_W'($urandom_range(0, 511));
      end else begin
        scl_dim[d] = SCALE_W'($urandom());
      end
    end
    for (int p = 0; p < n_points; p++) begin
      for (int d = 0; d < n_dims; d++) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          c = COORD_BITS'($urandom());
        end else if (pick == 1) begin
          c = q_dim[d];
        end else begin
          delta = $urandom_range(0, 1 << $urandom_range(0, 14));
          c = ($urandom_range(1) != 0) ? q_dim[d] + COORD_BITS'(delta)
                                       : q_dim[d] - COORD_BITS'(delta);
        end
        end_dim = (d == n_dims - 1) ^ ($urandom_range(24) == 0);
        end_set = ((p == n_points - 1) && (d == n_dims - 1)) || ($urandom_range(99) == 0);
        send_word(make_word(c, q_dim[d], tol_dim[d], scl_dim[d], end_dim, end_set));
        if (end_set) begin
          return;
        end
      end
    end
  endtask

  initial begin
    int unsigned phase_end;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(make_word(MAX_COORD, MIN_COORD, 0, 0, 1'b0, 1'b1));
    send_word(make_word(MIN_COORD, MAX_COORD, 0, 0, 1'b1, 1'b0));
    send_word(make_word(0, 0, 0, 0, 1'b1, 1'b1));
    send_word(make_word(5, 3, 0, 0, 1'b1, 1'b0));
    send_word(make_word(1, 3, 0, 0, 1'b1, 1'b1));
    drain();
    configure(1'b1, 1'b1);
    send_word(make_word(10, 0, 9, 256, 1'b1, 1'b0));
    send_word(make_word(COORD_BITS'(-10), 0, 10, 256, 1'b1, 1'b1));
    send_word(make_word(MAX_COORD, 0, MAX_TOL, MAX_SCALE, 1'b1, 1'b1));
    send_word(make_word(MIN_COORD, 0, MAX_TOL, 0, 1'b1, 1'b1));
    drain();
    configure(1'b0, 1'b1);
    send_word(make_word(MAX_COORD, MIN_COORD, 0, MAX_SCALE, 1'b0, 1'b0));
    send_word(make_word(MIN_COORD, MAX_COORD, 0, MAX_SCALE, 1'b1, 1'b0));
    send_word(make_word(MAX_COORD, MIN_COORD, 0, MAX_SCALE, 1'b1, 1'b0));
    send_word(make_word(1, 0, 0, 127, 1'b1, 1'b0));
    send_word(make_word(0, 1, 0, 128, 1'b1, 1'b1));
    drain();
    configure(1'b0, 1'b0);
    send_word(make_word(3, 0, 0, MAX_SCALE, 1'b1, 1'b0));
    send_word(make_word(0, 0, 0, MAX_SCALE, 1'b0, 1'b0));
    send_word(make_word(2, 0, 0, 0, 1'b1, 1'b1));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      configure(phase[0] ^ phase[2], phase[1]);
      case (phase % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 88;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 88;
        end
        default: begin
          tx_idle_pct  = 12;
          rx_stall_pct = 12;
        end
      endcase
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) send_random_set();
    end

    drain();
    configure(1'b1, 1'b1);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left <= HOLD_CYCLES;
    phase_end = words_sent + HOLD_WORDS;
    while (words_sent < phase_end) send_random_set();

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
